// ----- sv/pmrss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmrss_pkg
// Shared types and constants of the pointer motion rotate / smooth / scroll
// conditioner: sin/cos table, filter coefficients, sequencer states.
// ----------------------------------------------------------------------------
package pmrss_pkg;

    localparam int FRAC_BITS_DEF   = 8;
    localparam int ANGLE_STEPS_DEF = 13;
    localparam int TRIG_BITS       = 14;
    localparam int TABLE_LEN       = 13;
    localparam int ZERO_ANGLE_IDX  = 6;
    localparam int IIR_OLD         = 717;
    localparam int IIR_NEW         = 307;
    localparam int IIR_BITS        = 10;
    localparam int FILT_W          = 20;
    localparam int SACC_W          = 16;

    // register indexes
    localparam logic [1:0] REG_ROT    = 2'd0;
    localparam logic [1:0] REG_SDIV   = 2'd1;
    localparam logic [1:0] REG_SINV   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT_A,
        ST_ROT_B,
        ST_FILT_A,
        ST_FILT_B,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQRT,
        ST_GDIV,
        ST_GAIN,
        ST_SCALE_A,
        ST_SCALE_B,
        ST_ACC,
        ST_EMIT,
        ST_OUT
    } state_t;

    function automatic logic signed [15:0] sin_q14(input logic [3:0] i);
        logic signed [15:0] r;
        case (i)
            4'd0:    r = -16'sd16384;
            4'd1:    r = -16'sd15826;
            4'd2:    r = -16'sd14189;
            4'd3:    r = -16'sd11585;
            4'd4:    r = -16'sd8192;
            4'd5:    r = -16'sd4240;
            4'd6:    r = 16'sd0;
            4'd7:    r = 16'sd4240;
            4'd8:    r = 16'sd8192;
            4'd9:    r = 16'sd11585;
            4'd10:   r = 16'sd14189;
            4'd11:   r = 16'sd15826;
            4'd12:   r = 16'sd16384;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] cos_q14(input logic [3:0] i);
        logic signed [15:0] r;
        case (i)
            4'd0:    r = 16'sd0;
            4'd1:    r = 16'sd4240;
            4'd2:    r = 16'sd8192;
            4'd3:    r = 16'sd11585;
            4'd4:    r = 16'sd14189;
            4'd5:    r = 16'sd15826;
            4'd6:    r = 16'sd16384;
            4'd7:    r = 16'sd15826;
            4'd8:    r = 16'sd14189;
            4'd9:    r = 16'sd11585;
            4'd10:   r = 16'sd8192;
            4'd11:   r = 16'sd4240;
            4'd12:   r = 16'sd0;
            default: r = 16'sd16384;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/pointer_motion_rotate_smooth_scroll_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pointer_motion_rotate_smooth_scroll_top
// Rotates, smooths and speed-scales one motion report, then turns it into
// pointer counts or scroll steps.
// ----------------------------------------------------------------------------
// After a report is accepted, one shared signed multiplier is stepped
// through the rotation, filter, magnitude, gain divide and scale products,
// and the square root of the filtered magnitude runs one result bit per
// cycle, before the result beat is offered. The block accepts one report at
// a time; the result is held until taken, and the next report is accepted
// the cycle after that, so any time the receiver holds the result off also
// delays the next report.
module pointer_motion_rotate_smooth_scroll_top #(
    parameter int FRAC_BITS   = pmrss_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_STEPS = pmrss_pkg::ANGLE_STEPS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic signed [7:0] dx,
    input  wire logic signed [7:0] dy,
    input  wire logic signed [7:0] wheel_h_in,
    input  wire logic signed [7:0] wheel_v_in,
    input  wire logic              scroll_mode,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [7:0]      move_x,
    output logic signed [7:0]      move_y,
    output logic signed [7:0]      wheel_h_out,
    output logic signed [7:0]      wheel_v_out,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [3:0]        cfg_data
);
    import pmrss_pkg::*;

    localparam int RSH   = TRIG_BITS - FRAC_BITS;
    localparam int SQ_W  = 2 * FILT_W;       // sum of squares, unsigned
    localparam int RT_W  = FILT_W;           // root width
    localparam int SQ_IT = SQ_W / 2;
    localparam int GBASE = (3 << FRAC_BITS) >> 1;
    localparam int GMAXV = (9 << FRAC_BITS) >> 1;
    localparam int GW    = FRAC_BITS + 5;
    localparam int PW    = 48;
    // divide by five as multiply by (2^22 + 1) / 5, exact below 2^20
    localparam int DIV5_MUL = 838861;
    localparam int DIV5_SH  = 22;
    localparam logic signed [FILT_W-1:0] FMAX = {1'b0, {(FILT_W-1){1'b1}}};
    localparam logic signed [FILT_W-1:0] FMIN = {1'b1, {(FILT_W-1){1'b0}}};
    localparam logic signed [SACC_W-1:0] SMAX = {1'b0, {(SACC_W-1){1'b1}}};
    localparam logic signed [SACC_W-1:0] SMIN = {1'b1, {(SACC_W-1){1'b0}}};

    // configuration
    logic [3:0] rot_reg;
    logic [2:0] sdiv_reg;
    logic       sinv_reg;

    state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    logic signed [7:0]  x_reg, y_reg, wh_reg, wv_reg;
    logic               scr_reg;
    logic signed [15:0] s_reg, c_reg;
    logic signed [FILT_W-1:0] rx_reg, ry_reg;
    logic signed [FILT_W-1:0] fx_reg, fy_reg;
    logic signed [FILT_W-1:0] px_reg, py_reg;
    logic signed [SACC_W-1:0] ah_reg, av_reg;
    logic signed [PW-1:0] acc_reg;          // product accumulator
    logic [SQ_W-1:0] sqn_reg;
    logic [SQ_W-1:0] sqr_reg;
    logic [GW-1:0]   gain_reg;
    logic signed [PW-1:0] sx_reg, sy_reg;
    logic signed [7:0] ox_reg, oy_reg, oh_reg, ov_reg;
    logic ovalid_reg;

    // shared multiplier operands
    logic signed [FILT_W:0] ma, mb;
    logic signed [PW-1:0]   prod;

    // 3 * magnitude, quartered before the divide by five
    logic [RT_W+1:0] mag3;
    assign mag3 = {sqr_reg[RT_W-1:0], 1'b0} + (RT_W+2)'(sqr_reg[RT_W-1:0]);

    // ------------------------------------------------------------------
    // helpers
    function automatic logic signed [PW-1:0] floor_shr(input logic signed [PW-1:0] v,
                                                      input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [PW-1:0] trunc_shr(input logic signed [PW-1:0] v,
                                                      input int s);
        logic signed [PW-1:0] a;
        a = v < 0 ? -v : v;
        a = a >>> s;
        return v < 0 ? -a : a;
    endfunction

    function automatic logic signed [FILT_W-1:0] sat20(input logic signed [PW-1:0] v);
        if (v > PW'(FMAX)) return FMAX;
        if (v < PW'(FMIN)) return FMIN;
        return v[FILT_W-1:0];
    endfunction

    function automatic logic signed [SACC_W-1:0] sat16(input logic signed [PW-1:0] v);
        if (v > PW'(SMAX)) return SMAX;
        if (v < PW'(SMIN)) return SMIN;
        return v[SACC_W-1:0];
    endfunction

    function automatic logic signed [7:0] sat8(input logic signed [PW-1:0] v);
        if (v > 48'sd127)  return 8'sd127;
        if (v < -48'sd128) return -8'sd128;
        return v[7:0];
    endfunction

    // ------------------------------------------------------------------
    // operand select for the shared multiplier
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            ST_ROT_A:   begin ma = (FILT_W+1)'(x_reg);  mb = (FILT_W+1)'(c_reg); end
            ST_ROT_B:   begin ma = (FILT_W+1)'(y_reg);  mb = (FILT_W+1)'(s_reg); end
            ST_FILT_A:  begin ma = (FILT_W+1)'(cnt_reg[0] ? fy_reg : fx_reg);
                              mb = (FILT_W+1)'(IIR_OLD); end
            ST_FILT_B:  begin ma = (FILT_W+1)'(cnt_reg[0] ? ry_reg : rx_reg);
                              mb = (FILT_W+1)'(IIR_NEW); end
            ST_SQ_A:    begin ma = (FILT_W+1)'(fx_reg); mb = (FILT_W+1)'(fx_reg); end
            ST_SQ_B:    begin ma = (FILT_W+1)'(fy_reg); mb = (FILT_W+1)'(fy_reg); end
            ST_GDIV:    begin ma = (FILT_W+1)'(mag3[RT_W+1:2]);
                              mb = (FILT_W+1)'(DIV5_MUL); end
            ST_SCALE_A: begin ma = (FILT_W+1)'(fx_reg);
                              mb = (FILT_W+1)'($signed({1'b0, gain_reg})); end
            ST_SCALE_B: begin ma = (FILT_W+1)'(fy_reg);
                              mb = (FILT_W+1)'($signed({1'b0, gain_reg})); end
            default:    begin ma = '0; mb = '0; end
        endcase
    end

    assign prod = PW'(ma * mb);

    // ------------------------------------------------------------------
    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) begin state_next = ST_ROT_A; cnt_next = '0; end
            ST_ROT_A:   begin state_next = ST_ROT_B; end
            ST_ROT_B:
            begin
                if (cnt_reg[0]) begin state_next = ST_FILT_A; cnt_next = '0; end
                else begin state_next = ST_ROT_A; cnt_next = 5'd1; end
            end
            ST_FILT_A:  state_next = ST_FILT_B;
            ST_FILT_B:
            begin
                if (cnt_reg[0]) begin state_next = ST_SQ_A; cnt_next = '0; end
                else begin state_next = ST_FILT_A; cnt_next = 5'd1; end
            end
            ST_SQ_A:    state_next = ST_SQ_B;
            ST_SQ_B:    begin state_next = ST_SQRT; cnt_next = '0; end
            ST_SQRT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQ_IT - 1)) state_next = ST_GDIV;
            end
            ST_GDIV:    state_next = ST_GAIN;
            ST_GAIN:    state_next = ST_SCALE_A;
            ST_SCALE_A: state_next = ST_SCALE_B;
            ST_SCALE_B: state_next = ST_ACC;
            ST_ACC:     state_next = ST_EMIT;
            ST_EMIT:    state_next = ST_OUT;
            ST_OUT:     if (out_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = ovalid_reg;
        cfg_ready = (state_reg == ST_IDLE);
    end

    // square root step values
    logic [SQ_W-1:0] sq_bit;
    logic [SQ_W-1:0] sq_trial;
    assign sq_bit   = SQ_W'(1) << (SQ_W - 2 - 2 * int'(cnt_reg));
    assign sq_trial = sqr_reg + sq_bit;

    // scroll / pointer intermediate values
    logic signed [PW-1:0] ix, iy, ax, ay, nh, nv, hs, vs, pxn, pyn, mx, my;
    logic [2:0] sh;
    always_comb
    begin
        sh  = (sdiv_reg > 3'd5 ? 3'd5 : sdiv_reg) + 3'd1;
        ix  = trunc_shr(sx_reg, FRAC_BITS);
        iy  = trunc_shr(sy_reg, FRAC_BITS);
        ax  = ix < 0 ? -ix : ix;
        ay  = iy < 0 ? -iy : iy;
        if (ax > ay) iy = '0;
        else         ix = '0;
        if (sinv_reg)
        begin
            nh = PW'(ah_reg) + ix;
            nv = PW'(av_reg) - iy;
        end
        else
        begin
            nh = PW'(ah_reg) - ix;
            nv = PW'(av_reg) + iy;
        end
        pxn = PW'(px_reg) + floor_shr(sx_reg, 1);
        pyn = PW'(py_reg) + floor_shr(sy_reg, 1);
        hs  = PW'(sat8(PW'(ah_reg) >>> sh));
        vs  = PW'(sat8(PW'(av_reg) >>> sh));
        mx  = PW'(sat8(trunc_shr(PW'(px_reg), FRAC_BITS)));
        my  = PW'(sat8(trunc_shr(PW'(py_reg), FRAC_BITS)));
    end

    logic [3:0] ai;
    assign ai = (int'(rot_reg) >= ANGLE_STEPS || int'(rot_reg) >= TABLE_LEN)
                ? 4'(ZERO_ANGLE_IDX) : rot_reg;

    // gain = 1.5 + 3*|v|/20, quotient taken from the top of the divide product
    logic signed [PW-1:0] gsum;
    assign gsum = PW'(GBASE) + (acc_reg >>> DIV5_SH);

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            rot_reg    <= 4'd3;
            sdiv_reg   <= 3'd4;
            sinv_reg   <= 1'b1;
            fx_reg     <= '0;
            fy_reg     <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            ah_reg     <= '0;
            av_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROT:  rot_reg  <= cfg_data;
                    REG_SDIV: sdiv_reg <= cfg_data[2:0];
                    REG_SINV: sinv_reg <= cfg_data[0];
                    default:  ;
                endcase
            end
            if (state_reg == ST_EMIT) ovalid_reg <= 1'b1;
            else if (out_ready)       ovalid_reg <= 1'b0;
            if (state_reg == ST_FILT_B)
            begin
                if (cnt_reg[0]) fy_reg <= sat20((acc_reg + prod + PW'(1 << (IIR_BITS-1)))
                                               >>> IIR_BITS);
                else            fx_reg <= sat20((acc_reg + prod + PW'(1 << (IIR_BITS-1)))
                                               >>> IIR_BITS);
            end
            if (state_reg == ST_ACC)
            begin
                if (scr_reg)
                begin
                    ah_reg <= sat16(nh);
                    av_reg <= sat16(nv);
                end
                else
                begin
                    px_reg <= sat20(pxn);
                    py_reg <= sat20(pyn);
                end
            end
            if (state_reg == ST_EMIT)
            begin
                if (scr_reg)
                begin
                    ah_reg <= SACC_W'(PW'(ah_reg) - (hs <<< sh));
                    av_reg <= SACC_W'(PW'(av_reg) - (vs <<< sh));
                end
                else
                begin
                    px_reg <= FILT_W'(PW'(px_reg) - (mx <<< FRAC_BITS));
                    py_reg <= FILT_W'(PW'(py_reg) - (my <<< FRAC_BITS));
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x_reg   <= dx;
                y_reg   <= dy;
                wh_reg  <= wheel_h_in;
                wv_reg  <= wheel_v_in;
                scr_reg <= scroll_mode;
                s_reg   <= sin_q14(ai);
                c_reg   <= cos_q14(ai);
            end
            ST_ROT_A:   acc_reg <= prod;
            ST_ROT_B:
            begin
                if (cnt_reg[0])
                    ry_reg <= FILT_W'((acc_reg + prod + PW'(1 << (RSH-1))) >>> RSH);
                else
                begin
                    rx_reg <= FILT_W'((-(acc_reg + prod) + PW'(1 << (RSH-1))) >>> RSH);
                    // second pass computes -x*s + y*c
                    s_reg  <= c_reg;
                    c_reg  <= -s_reg;
                end
            end
            ST_FILT_A:  acc_reg <= prod;
            ST_SQ_A:    acc_reg <= prod;
            ST_SQ_B:
            begin
                sqn_reg <= SQ_W'(acc_reg + prod);
                sqr_reg <= '0;
            end
            ST_SQRT:
            begin
                if (sqn_reg >= sq_trial)
                begin
                    sqn_reg <= sqn_reg - sq_trial;
                    sqr_reg <= (sqr_reg >> 1) + sq_bit;
                end
                else
                    sqr_reg <= sqr_reg >> 1;
            end
            ST_GDIV:    acc_reg <= prod;
            ST_GAIN:    gain_reg <= gsum > PW'(GMAXV) ? GW'(GMAXV) : GW'(gsum);
            ST_SCALE_A: sx_reg <= (prod + PW'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
            ST_SCALE_B: sy_reg <= (prod + PW'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
            ST_EMIT:
            begin
                if (scr_reg)
                begin
                    ox_reg <= '0;
                    oy_reg <= '0;
                    oh_reg <= sat8(PW'(wh_reg) + hs);
                    ov_reg <= sat8(PW'(wv_reg) + vs);
                end
                else
                begin
                    ox_reg <= mx[7:0];
                    oy_reg <= my[7:0];
                    oh_reg <= wh_reg;
                    ov_reg <= wv_reg;
                end
            end
            default: ;
        endcase
    end

    assign move_x      = ox_reg;
    assign move_y      = oy_reg;
    assign wheel_h_out = oh_reg;
    assign wheel_v_out = ov_reg;

    // ------------------------------------------------------------------
    // checks
    a_out_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_OUT || state_reg == ST_IDLE))
        else $error("result beat outside output state");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |=> out_valid)
        else $error("result not raised after emit");

endmodule
`default_nettype wire

// ----- test/tb_pointer_motion_rotate_smooth_scroll_top.sv -----
// ----------------------------------------------------------------------------
// tb_pointer_motion_rotate_smooth_scroll_top
// Self-checking bench for the motion conditioner: a short directed table,
// then phases of random reports under several register settings, each result
// beat compared with a typed table value or with a cycle-free prediction of
// rotation, IIR, gain and the pointer / scroll accumulators.
// ----------------------------------------------------------------------------
module tb_pointer_motion_rotate_smooth_scroll_top;
    import pmrss_pkg::*;

    typedef struct packed {
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic signed [7:0] wh;
        logic signed [7:0] wv;
        logic              scroll;
    } report_t;

    typedef struct packed {
        logic signed [7:0] mx;
        logic signed [7:0] my;
        logic signed [7:0] wh;
        logic signed [7:0] wv;
    } motion_out_t;

    typedef struct packed {
        report_t     rep;
        logic        known;
        motion_out_t res;
    } table_row_t;

    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 125;
    localparam int SETTLE      = 40;

    localparam int SIN_TAB [13] = '{-16384, -15826, -14189, -11585, -8192, -4240, 0,
                                    4240, 8192, 11585, 14189, 15826, 16384};
    localparam int COS_TAB [13] = '{0, 4240, 8192, 11585, 14189, 15826, 16384,
                                    15826, 14189, 11585, 8192, 4240, 0};

    logic clk;
    logic rst_n;
    logic in_valid, in_ready;
    logic signed [7:0] dx, dy, wheel_h_in, wheel_v_in;
    logic scroll_mode;
    logic out_valid, out_ready;
    logic signed [7:0] move_x, move_y, wheel_h_out, wheel_v_out;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;

    pointer_motion_rotate_smooth_scroll_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .dx(dx), .dy(dy), .wheel_h_in(wheel_h_in), .wheel_v_in(wheel_v_in),
        .scroll_mode(scroll_mode),
        .out_valid(out_valid), .out_ready(out_ready),
        .move_x(move_x), .move_y(move_y),
        .wheel_h_out(wheel_h_out), .wheel_v_out(wheel_v_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state and register copies
    int unsigned rot_sel, div_sel, inv_sel;
    longint filt_x, filt_y, frac_x, frac_y, sacc_h, sacc_v;

    motion_out_t expected_q[$];
    int errors;
    int n_pointer, n_scroll, n_phases_run;
    bit no_gaps;
    int ready_pct;
    bit hold_req;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        #50_000_000;
        $display("[pointer_motion_rotate_smooth_scroll_top] ERROR");
        $finish;
    end

    function automatic longint sat_w(longint v, int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint rnd_shr(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint trunc_shr(longint v, int s);
        return v >= 0 ? (v >>> s) : -((-v) >>> s);
    endfunction

    function automatic longint iroot(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint abs_l(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Conditions one report and advances the filter / accumulator state.
    function automatic motion_out_t condition_report(report_t r);
        motion_out_t o;
        longint x, y, s, c, rx, ry, mag, gain, sx, sy, ix, iy, hs, vs, mx, my;
        int unsigned ai, sh;
        x = longint'(r.dx);
        y = longint'(r.dy);
        ai = rot_sel >= 13 ? 6 : rot_sel;
        s = SIN_TAB[ai];
        c = COS_TAB[ai];
        rx = rnd_shr(-(x * c + y * s), 6);
        ry = rnd_shr(-x * s + y * c, 6);
        filt_x = sat_w(rnd_shr(filt_x * 717 + rx * 307, 10), 20);
        filt_y = sat_w(rnd_shr(filt_y * 717 + ry * 307, 10), 20);
        mag = iroot(longint'(filt_x * filt_x + filt_y * filt_y));
        gain = 384 + (3 * mag) / 20;
        if (gain > 1152) gain = 1152;
        sx = rnd_shr(filt_x * gain, 8);
        sy = rnd_shr(filt_y * gain, 8);
        if (r.scroll) begin
            ix = trunc_shr(sx, 8);
            iy = trunc_shr(sy, 8);
            sh = (div_sel > 5 ? 5 : div_sel) + 1;
            if (abs_l(ix) > abs_l(iy)) iy = 0;
            else ix = 0;
            if (inv_sel != 0) begin
                sacc_h = sat_w(sacc_h + ix, 16);
                sacc_v = sat_w(sacc_v - iy, 16);
            end else begin
                sacc_h = sat_w(sacc_h - ix, 16);
                sacc_v = sat_w(sacc_v + iy, 16);
            end
            hs = sat_w(sacc_h >>> sh, 8);
            vs = sat_w(sacc_v >>> sh, 8);
            sacc_h = sacc_h - (hs <<< sh);
            sacc_v = sacc_v - (vs <<< sh);
            o.mx = '0;
            o.my = '0;
            o.wh = 8'(sat_w(longint'(r.wh) + hs, 8));
            o.wv = 8'(sat_w(longint'(r.wv) + vs, 8));
        end else begin
            frac_x = sat_w(frac_x + (sx >>> 1), 20);
            frac_y = sat_w(frac_y + (sy >>> 1), 20);
            mx = sat_w(trunc_shr(frac_x, 8), 8);
            my = sat_w(trunc_shr(frac_y, 8), 8);
            frac_x = frac_x - (mx <<< 8);
            frac_y = frac_y - (my <<< 8);
            o.mx = 8'(mx);
            o.my = 8'(my);
            o.wh = r.wh;
            o.wv = r.wv;
        end
        return o;
    endfunction

    function automatic int gap_len();
        int p;
        if (no_gaps) return 0;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [7:0] clip8(int v);
        return v > 127 ? 8'sd127 : (v < -128 ? -8'sd128 : 8'(v));
    endfunction

    // Offers one report beat and records its expected result on acceptance.
    task automatic send_report(report_t r, bit known, motion_out_t typed);
        int g;
        motion_out_t p;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid    <= 1'b1;
        dx          <= r.dx;
        dy          <= r.dy;
        wheel_h_in  <= r.wh;
        wheel_v_in  <= r.wv;
        scroll_mode <= r.scroll;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        p = condition_report(r);
        expected_q.push_back(known ? typed : p);
        if (r.scroll) n_scroll++;
        else n_pointer++;
    endtask

    // Leaves valid up so that writes run back to back; the caller drops it.
    task automatic cfg_write(logic [1:0] idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_ROT:  rot_sel = 32'(val);
            REG_SDIV: div_sel = 32'(val[2:0]);
            REG_SINV: inv_sel = 32'(val[0]);
            default:  ;
        endcase
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk) begin
        motion_out_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (move_x !== e.mx) begin
                    $error("move_x: expected %0d, got %0d", e.mx, move_x);
                    errors++;
                end
                if (move_y !== e.my) begin
                    $error("move_y: expected %0d, got %0d", e.my, move_y);
                    errors++;
                end
                if (wheel_h_out !== e.wh) begin
                    $error("wheel_h_out: expected %0d, got %0d", e.wh, wheel_h_out);
                    errors++;
                end
                if (wheel_v_out !== e.wv) begin
                    $error("wheel_v_out: expected %0d, got %0d", e.wv, wheel_v_out);
                    errors++;
                end
            end
        end
    end

    // receiver: random back-pressure, occasional long stall, and one long hold-off
    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end else if ($urandom_range(0, 199) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    initial begin
        table_row_t dir_tab [16];
        report_t r;
        motion_out_t none;
        int bx, by, mode, p;

        rst_n = 1'b0;
        in_valid = 1'b0;
        dx = '0; dy = '0; wheel_h_in = '0; wheel_v_in = '0; scroll_mode = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        errors = 0; n_pointer = 0; n_scroll = 0; n_phases_run = 0;
        no_gaps = 1'b0; ready_pct = 80; hold_req = 1'b0;
        rot_sel = 3; div_sel = 4; inv_sel = 1;
        filt_x = 0; filt_y = 0; frac_x = 0; frac_y = 0; sacc_h = 0; sacc_v = 0;
        none = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle reports with extreme wheels, then extreme motion both modes
        dir_tab[0]  = '{'{8'sd0, 8'sd0, 8'sd127, -8'sd128, 1'b0}, 1'b1,
                        '{8'sd0, 8'sd0, 8'sd127, -8'sd128}};
        dir_tab[1]  = '{'{8'sd0, 8'sd0, -8'sd128, 8'sd127, 1'b1}, 1'b1,
                        '{8'sd0, 8'sd0, -8'sd128, 8'sd127}};
        dir_tab[2]  = '{'{8'sd127, 8'sd127, 8'sd0, 8'sd0, 1'b0}, 1'b0, none};
        dir_tab[3]  = '{'{8'sd127, 8'sd127, 8'sd0, 8'sd0, 1'b0}, 1'b0, none};
        dir_tab[4]  = '{'{-8'sd128, -8'sd128, 8'sd1, -8'sd1, 1'b0}, 1'b0, none};
        dir_tab[5]  = '{'{8'sd127, -8'sd128, 8'sd0, 8'sd0, 1'b0}, 1'b0, none};
        dir_tab[6]  = '{'{-8'sd128, 8'sd127, 8'sd0, 8'sd0, 1'b0}, 1'b0, none};
        dir_tab[7]  = '{'{8'sd127, 8'sd0, 8'sd127, 8'sd127, 1'b1}, 1'b0, none};
        dir_tab[8]  = '{'{8'sd127, 8'sd0, 8'sd127, 8'sd127, 1'b1}, 1'b0, none};
        dir_tab[9]  = '{'{8'sd127, 8'sd0, 8'sd127, 8'sd127, 1'b1}, 1'b0, none};
        dir_tab[10] = '{'{8'sd0, -8'sd128, -8'sd128, -8'sd128, 1'b1}, 1'b0, none};
        dir_tab[11] = '{'{8'sd0, -8'sd128, -8'sd128, -8'sd128, 1'b1}, 1'b0, none};
        dir_tab[12] = '{'{8'sd5, 8'sd5, 8'sd0, 8'sd0, 1'b1}, 1'b0, none};
        dir_tab[13] = '{'{-8'sd1, 8'sd1, 8'sd0, 8'sd0, 1'b0}, 1'b0, none};
        dir_tab[14] = '{'{8'sd0, 8'sd0, 8'sd0, 8'sd0, 1'b0}, 1'b0, none};
        dir_tab[15] = '{'{8'sd0, 8'sd0, 8'sd0, 8'sd0, 1'b1}, 1'b0, none};
        foreach (dir_tab[i])
            send_report(dir_tab[i].rep, dir_tab[i].known, dir_tab[i].res);
        wait_idle();

        // random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin cfg_write(REG_ROT, 4'd0);  cfg_write(REG_SDIV, 4'd0);
                         cfg_write(REG_SINV, 4'd0); end
                1: begin cfg_write(REG_ROT, 4'd12); cfg_write(REG_SDIV, 4'd5);
                         cfg_write(REG_SINV, 4'd1); end
                2: begin cfg_write(REG_ROT, 4'd15); cfg_write(REG_SDIV, 4'd7);
                         cfg_write(REG_SINV, 4'd0); end
                3: begin cfg_write(REG_ROT, 4'd6);  cfg_write(REG_SDIV, 4'd2); end
                default: begin
                    cfg_write(REG_ROT, 4'($urandom_range(0, 15)));
                    cfg_write(REG_SDIV, 4'($urandom_range(0, 7)));
                    cfg_write(REG_SINV, 4'($urandom_range(0, 1)));
                end
            endcase
            cfg_valid <= 1'b0;
            n_phases_run++;
            no_gaps   = (ph == 4);
            ready_pct = (ph == 4) ? 100 : $urandom_range(40, 95);
            bx = $urandom_range(0, 120) - 60;
            by = $urandom_range(0, 120) - 60;
            mode = $urandom_range(0, 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == 10) hold_req = 1'b1;
                if ($urandom_range(0, 19) == 0) mode = !mode;
                p = $urandom_range(0, 99);
                if (p < 80) begin
                    r.dx = clip8(bx + $urandom_range(0, 40) - 20);
                    r.dy = clip8(by + $urandom_range(0, 40) - 20);
                end else if (p < 90) begin
                    r.dx = 8'($urandom_range(0, 255));
                    r.dy = 8'($urandom_range(0, 255));
                end else begin
                    r.dx = '0;
                    r.dy = '0;
                end
                r.wh = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'sd0;
                r.wv = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'sd0;
                r.scroll = 1'(mode);
                send_report(r, 1'b0, none);
            end
            wait_idle();
        end

        $display("Covered %0d pointer and %0d scroll reports over %0d register settings.",
                 n_pointer, n_scroll, n_phases_run);
        if (errors == 0)
            $display("[pointer_motion_rotate_smooth_scroll_top] OK");
        else
            $display("[pointer_motion_rotate_smooth_scroll_top] ERROR");
        $finish;
    end

endmodule
